// ----- rtl/arp_single_entry_resolver_top_defines.svh -----
// Assertion macros used by the ARP single entry resolver checker.
`ifndef ARP_SINGLE_ENTRY_RESOLVER_TOP_DEFINES_SVH
`define ARP_SINGLE_ENTRY_RESOLVER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARPSER_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("arp resolver check failed");

// Consequent must hold in the cycle after the antecedent.
`define ARPSER_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("arp resolver check failed");

`endif

// ----- rtl/arpser_pkg.sv -----
// Types and constants shared by the ARP single entry resolver modules.
`timescale 1ns / 1ps
`default_nettype none

package arpser_pkg;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_RX_ARP  = 2'd1,
    OP_RESOLVE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_REQUEST = 2'd1,
    ACT_REPLY   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_FREE      = 2'd0,
    ST_OK        = 2'd1,
    ST_RESOLVING = 2'd2
  } ent_state_e;

  typedef enum logic [1:0] {
    CFG_LOCAL_IP        = 2'd0,
    CFG_OK_TIMEOUT      = 2'd1,
    CFG_PENDING_TIMEOUT = 2'd2,
    CFG_MAX_RETRIES     = 2'd3
  } cfg_idx_e;

  localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
  localparam logic [15:0] PROTO_TYPE_IP4 = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
  localparam logic [7:0]  PROTO_LEN_IP4  = 8'd4;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

  localparam logic [31:0] LOCAL_IP_RST        = 32'd0;
  localparam logic [15:0] OK_TIMEOUT_RST      = 16'd5;
  localparam logic [15:0] PENDING_TIMEOUT_RST = 16'd1;
  localparam logic [7:0]  MAX_RETRIES_RST     = 8'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        frame_long_enough;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic [15:0] arp_operation;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
    logic [31:0] tgt_ip;
    logic [31:0] query_ip;
  } item_t;

  typedef struct packed {
    ent_state_e  st;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [15:0] ticks;
    logic [7:0]  retries;
  } entry_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [15:0] ok_timeout;
    logic [15:0] pending_timeout;
    logic [7:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] action_ip;
    logic [47:0] action_mac;
    logic        resolve_hit;
    logic [47:0] resolved_mac;
    ent_state_e  entry_status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/arpser_step.sv -----
// Next-entry and result logic for one event applied to the cache entry.
`timescale 1ns / 1ps
`default_nettype none

module arpser_step (
  input  arpser_pkg::item_t   item_i,
  input  arpser_pkg::entry_t  entry_i,
  input  arpser_pkg::cfg_t    cfg_i,
  output arpser_pkg::entry_t  entry_o,
  output arpser_pkg::result_t result_o
);

  logic [15:0] ticks_dec;
  logic        hdr_ok;
  logic        oper_ok;

  assign ticks_dec = entry_i.ticks - 16'd1;
  assign oper_ok   = (item_i.arp_operation == arpser_pkg::ARP_OP_REQUEST) ||
                     (item_i.arp_operation == arpser_pkg::ARP_OP_REPLY);
  assign hdr_ok    = item_i.frame_long_enough &&
                     (item_i.hw_type == arpser_pkg::HW_TYPE_ETH) &&
                     (item_i.proto_type == arpser_pkg::PROTO_TYPE_IP4) &&
                     (item_i.hw_len == arpser_pkg::HW_LEN_ETH) &&
                     (item_i.proto_len == arpser_pkg::PROTO_LEN_IP4) &&
                     oper_ok && (item_i.tgt_ip == cfg_i.local_ip);

  always_comb begin
    entry_o               = entry_i;
    result_o.action       = arpser_pkg::ACT_NONE;
    result_o.action_ip    = '0;
    result_o.action_mac   = '0;
    result_o.resolve_hit  = 1'b0;
    result_o.resolved_mac = '0;

    unique case (arpser_pkg::opcode_e'(item_i.opcode))
      arpser_pkg::OP_TICK: begin
        if (entry_i.st != arpser_pkg::ST_FREE) begin
          entry_o.ticks = ticks_dec;
          if (ticks_dec == '0) begin
            if (entry_i.st == arpser_pkg::ST_RESOLVING && entry_i.retries == '0) begin
              entry_o.st = arpser_pkg::ST_FREE;
            end else begin
              if (entry_i.st == arpser_pkg::ST_RESOLVING) begin
                entry_o.retries = entry_i.retries - 8'd1;
              end
              entry_o.st         = arpser_pkg::ST_RESOLVING;
              entry_o.ticks      = cfg_i.pending_timeout;
              result_o.action    = arpser_pkg::ACT_REQUEST;
              result_o.action_ip = entry_i.ip;
            end
          end
        end
      end
      arpser_pkg::OP_RX_ARP: begin
        if (hdr_ok) begin
          entry_o.st      = arpser_pkg::ST_OK;
          entry_o.ip      = item_i.src_ip;
          entry_o.mac     = item_i.src_mac;
          entry_o.ticks   = cfg_i.ok_timeout;
          entry_o.retries = cfg_i.max_retries;
          if (item_i.arp_operation == arpser_pkg::ARP_OP_REQUEST) begin
            result_o.action     = arpser_pkg::ACT_REPLY;
            result_o.action_ip  = item_i.src_ip;
            result_o.action_mac = item_i.src_mac;
          end
        end
      end
      arpser_pkg::OP_RESOLVE: begin
        if (entry_i.st == arpser_pkg::ST_OK && entry_i.ip == item_i.query_ip) begin
          result_o.resolve_hit  = 1'b1;
          result_o.resolved_mac = entry_i.mac;
        end else begin
          result_o.action    = arpser_pkg::ACT_REQUEST;
          result_o.action_ip = item_i.query_ip;
        end
      end
      default: begin
      end
    endcase

    result_o.entry_status = entry_o.st;
  end

endmodule

`default_nettype wire

// ----- rtl/arp_single_entry_resolver_top.sv -----
// Top level of the one-entry ARP cache with its configuration registers.
// Each transfer is one event (timer tick, received ARP header or resolve query) and
// gives exactly one result transfer. Events enter an input register, the entry is
// updated and the result is captured in an output register as the event leaves
// that register, so a result is presented from the output register once its event
// has left the input register. The block takes one event per cycle while the result
// is not stalled; the rate is set by the single read-modify-write of the entry
// register, which holds one event's update per cycle. The input stalls only while an
// event waits in the input register behind a stalled result. Configuration writes
// take effect at the next clock edge.
`timescale 1ns / 1ps
`default_nettype none

module arp_single_entry_resolver_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic        frame_long_enough_i,
  input  wire logic [15:0] hw_type_i,
  input  wire logic [15:0] proto_type_i,
  input  wire logic [7:0]  hw_len_i,
  input  wire logic [7:0]  proto_len_i,
  input  wire logic [15:0] arp_operation_i,
  input  wire logic [31:0] src_ip_i,
  input  wire logic [47:0] src_mac_i,
  input  wire logic [31:0] tgt_ip_i,
  input  wire logic [31:0] query_ip_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       action_o,
  output logic [31:0]      action_ip_o,
  output logic [47:0]      action_mac_o,
  output logic             resolve_hit_o,
  output logic [47:0]      resolved_mac_o,
  output logic [1:0]       entry_status_o
);

  arpser_pkg::cfg_t       cfg_q;
  arpser_pkg::item_t      item_q;
  logic                   item_valid_q;
  arpser_pkg::ent_state_e ent_st_q;
  logic [31:0]            ent_ip_q;
  logic [47:0]            ent_mac_q;
  logic [15:0]            ent_ticks_q;
  logic [7:0]             ent_retries_q;
  arpser_pkg::entry_t     entry_cur;
  arpser_pkg::entry_t     entry_d;
  arpser_pkg::result_t    res_d;
  arpser_pkg::result_t    res_q;
  logic                   out_valid_q;
  logic                   out_free;
  logic                   step_fire;
  logic                   in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_fire  = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.local_ip        <= arpser_pkg::LOCAL_IP_RST;
      cfg_q.ok_timeout      <= arpser_pkg::OK_TIMEOUT_RST;
      cfg_q.pending_timeout <= arpser_pkg::PENDING_TIMEOUT_RST;
      cfg_q.max_retries     <= arpser_pkg::MAX_RETRIES_RST;
    end else if (cfg_we_i) begin
      unique case (arpser_pkg::cfg_idx_e'(cfg_idx_i))
        arpser_pkg::CFG_LOCAL_IP:        cfg_q.local_ip        <= cfg_wdata_i;
        arpser_pkg::CFG_OK_TIMEOUT:      cfg_q.ok_timeout      <= cfg_wdata_i[15:0];
        arpser_pkg::CFG_PENDING_TIMEOUT: cfg_q.pending_timeout <= cfg_wdata_i[15:0];
        arpser_pkg::CFG_MAX_RETRIES:     cfg_q.max_retries     <= cfg_wdata_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      ent_st_q     <= arpser_pkg::ST_FREE;
    end else begin
      if (in_take) begin
        item_valid_q <= 1'b1;
      end else if (step_fire) begin
        item_valid_q <= 1'b0;
      end
      if (step_fire) begin
        out_valid_q <= 1'b1;
        ent_st_q    <= entry_d.st;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.opcode            <= opcode_i;
      item_q.frame_long_enough <= frame_long_enough_i;
      item_q.hw_type           <= hw_type_i;
      item_q.proto_type        <= proto_type_i;
      item_q.hw_len            <= hw_len_i;
      item_q.proto_len         <= proto_len_i;
      item_q.arp_operation     <= arp_operation_i;
      item_q.src_ip            <= src_ip_i;
      item_q.src_mac           <= src_mac_i;
      item_q.tgt_ip            <= tgt_ip_i;
      item_q.query_ip          <= query_ip_i;
    end
    if (step_fire) begin
      ent_ip_q      <= entry_d.ip;
      ent_mac_q     <= entry_d.mac;
      ent_ticks_q   <= entry_d.ticks;
      ent_retries_q <= entry_d.retries;
      res_q         <= res_d;
    end
  end

  assign entry_cur.st      = ent_st_q;
  assign entry_cur.ip      = ent_ip_q;
  assign entry_cur.mac     = ent_mac_q;
  assign entry_cur.ticks   = ent_ticks_q;
  assign entry_cur.retries = ent_retries_q;

  arpser_step u_step (
    .item_i   (item_q),
    .entry_i  (entry_cur),
    .cfg_i    (cfg_q),
    .entry_o  (entry_d),
    .result_o (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign action_o       = res_q.action;
  assign action_ip_o    = res_q.action_ip;
  assign action_mac_o   = res_q.action_mac;
  assign resolve_hit_o  = res_q.resolve_hit;
  assign resolved_mac_o = res_q.resolved_mac;
  assign entry_status_o = res_q.entry_status;

endmodule

`default_nettype wire

// ----- rtl/arpser_checker.sv -----
// Port-level assertion checker for the ARP single entry resolver and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "arp_single_entry_resolver_top_defines.svh"

module arpser_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  action_o,
  input wire logic [31:0] action_ip_o,
  input wire logic        resolve_hit_o,
  input wire logic [47:0] resolved_mac_o,
  input wire logic [1:0]  entry_status_o
);

  logic        out_held;
  logic        hit_seen;
  logic        reply_seen;
  logic        st_is_ok;
  logic        act_is_none;
  logic [83:0] rslt_vec;

  assign out_held    = out_valid_o && out_stall_i;
  assign hit_seen    = out_valid_o && resolve_hit_o;
  assign reply_seen  = out_valid_o && (action_o == arpser_pkg::ACT_REPLY);
  assign st_is_ok    = entry_status_o == arpser_pkg::ST_OK;
  assign act_is_none = action_o == arpser_pkg::ACT_NONE;
  assign rslt_vec    = {action_o, action_ip_o, resolved_mac_o, entry_status_o};

  `ARPSER_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(rslt_vec))
  `ARPSER_ASSERT_NOW(a_hit_ok, clk_i, rst_ni, hit_seen, st_is_ok && act_is_none)
  `ARPSER_ASSERT_NOW(a_reply_ok, clk_i, rst_ni, reply_seen, st_is_ok && !resolve_hit_o)

endmodule

bind arp_single_entry_resolver_top arpser_checker u_arpser_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .action_o       (action_o),
  .action_ip_o    (action_ip_o),
  .resolve_hit_o  (resolve_hit_o),
  .resolved_mac_o (resolved_mac_o),
  .entry_status_o (entry_status_o)
);

`default_nettype wire
